@@ design/wqu_pkg.sv @@
// Shared definitions for the weighted quick-union engine.
// Holds the fixed port field widths and the sequencer state encoding.
// No dependencies.
package wqu_pkg;

   // Port field widths (fixed by the transaction format)
   localparam int ElemBits = 13;
   localparam int SizeBits = 14;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      SEQ_CLEAR  = 7'b0000001,
      SEQ_IDLE   = 7'b0000010,
      SEQ_WALK_A = 7'b0000100,
      SEQ_WALK_B = 7'b0001000,
      SEQ_LINK   = 7'b0010000,
      SEQ_GROW   = 7'b0100000,
      SEQ_DONE   = 7'b1000000
   } seq_state_type;

endpackage

@@ design/weighted_quick_union.sv @@
// Weighted quick-union engine. Each request transaction names two elements; the block walks
// parent links from each to its root, links the smaller tree under the larger (first root
// wins a tie) and returns both roots, a joined flag and the size of the combined set.
// Parent link and set size share one word in a single synchronous RAM with registered read
// data, and every link hop is one RAM read. An in-range item passes IDLE, WALK_A, WALK_B, LINK,
// GROW and DONE when the sets are merged and skips GROW when they are already joined; tree
// depth is bounded by log2(ELEMENTS), and no new request is taken until the sequencer is back in
// IDLE. An element at or above ELEMENTS returns the inputs as roots, joined 0, size 0.
// After reset the block runs a clearing pass over all entries (every entry becomes its own
// root with size one) and holds req_stall high until it ends. A finished result waits in an
// output register, so the next request is taken while the previous response is stalled.
// Depends on wqu_pkg and wqu_ram.
module weighted_quick_union #(
   parameter int ELEMENTS = 8192
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wqu_pkg::ElemBits-1:0]  req_element_a,
   input  logic [wqu_pkg::ElemBits-1:0]  req_element_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wqu_pkg::ElemBits-1:0]  rsp_root_a,
   output logic [wqu_pkg::ElemBits-1:0]  rsp_root_b,
   output logic                          rsp_joined,
   output logic [wqu_pkg::SizeBits-1:0]  rsp_merged_size
);

   localparam int IdxBits   = $clog2(ELEMENTS);
   localparam int CntBits   = $clog2(ELEMENTS + 1);
   localparam int EntryBits = IdxBits + CntBits;

   wqu_pkg::seq_state_type state_ff, state_in;

   logic [IdxBits-1:0]  clr_ff, clr_in;
   logic [IdxBits-1:0]  cur_ff, cur_in;
   logic [IdxBits-1:0]  elem_b_ff, elem_b_in;
   logic [IdxBits-1:0]  root_a_ff, root_a_in;
   logic [IdxBits-1:0]  root_b_ff, root_b_in;
   logic [CntBits-1:0]  size_a_ff, size_a_in;
   logic [CntBits-1:0]  size_b_ff, size_b_in;
   logic [IdxBits-1:0]  big_ff, big_in;

   // Result held between the walk and the output register
   logic [wqu_pkg::ElemBits-1:0] res_root_a_ff, res_root_a_in;
   logic [wqu_pkg::ElemBits-1:0] res_root_b_ff, res_root_b_in;
   logic                         res_joined_ff, res_joined_in;
   logic [CntBits-1:0]           res_size_ff, res_size_in;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [wqu_pkg::ElemBits-1:0] rsp_root_a_ff, rsp_root_a_in;
   logic [wqu_pkg::ElemBits-1:0] rsp_root_b_ff, rsp_root_b_in;
   logic                         rsp_joined_ff, rsp_joined_in;
   logic [wqu_pkg::SizeBits-1:0] rsp_size_ff, rsp_size_in;

   // RAM ports
   logic                 wr_en;
   logic [IdxBits-1:0]   wr_addr;
   logic [EntryBits-1:0] wr_data;
   logic                 rd_en;
   logic [IdxBits-1:0]   rd_addr;
   logic [EntryBits-1:0] rd_data;
   logic [IdxBits-1:0]   rd_parent;
   logic [CntBits-1:0]   rd_size;

   logic req_accept;
   logic req_range_bad;
   logic out_free;

   wqu_ram #(
      .DEPTH (ELEMENTS),
      .WIDTH (EntryBits)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_parent = rd_data[EntryBits-1:CntBits];
   assign rd_size   = rd_data[CntBits-1:0];

   assign req_stall  = (state_ff != wqu_pkg::SEQ_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_range_bad = (32'(req_element_a) >= ELEMENTS) || (32'(req_element_b) >= ELEMENTS);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Sequencer: clear, walk both roots, link, grow, hand off
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      elem_b_in     = elem_b_ff;
      root_a_in     = root_a_ff;
      root_b_in     = root_b_ff;
      size_a_in     = size_a_ff;
      size_b_in     = size_b_ff;
      big_in        = big_ff;
      res_root_a_in = res_root_a_ff;
      res_root_b_in = res_root_b_ff;
      res_joined_in = res_joined_ff;
      res_size_in   = res_size_ff;
      rsp_root_a_in = rsp_root_a_ff;
      rsp_root_b_in = rsp_root_b_ff;
      rsp_joined_in = rsp_joined_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = {clr_ff, CntBits'(1)};
      rd_en         = 1'b0;
      rd_addr       = cur_ff;

      unique case (state_ff)
         wqu_pkg::SEQ_CLEAR: begin
            // Make every entry its own root of size one
            wr_en  = 1'b1;
            clr_in = clr_ff + IdxBits'(1);
            if (clr_ff == IdxBits'(ELEMENTS - 1)) begin
               state_in = wqu_pkg::SEQ_IDLE;
            end
         end
         wqu_pkg::SEQ_IDLE: begin
            if (req_accept) begin
               if (req_range_bad) begin
                  // Echo the inputs with an error size
                  res_root_a_in = req_element_a;
                  res_root_b_in = req_element_b;
                  res_joined_in = 1'b0;
                  res_size_in   = '0;
                  state_in      = wqu_pkg::SEQ_DONE;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = IdxBits'(req_element_a);
                  cur_in    = IdxBits'(req_element_a);
                  elem_b_in = IdxBits'(req_element_b);
                  state_in  = wqu_pkg::SEQ_WALK_A;
               end
            end
         end
         wqu_pkg::SEQ_WALK_A: begin
            // Follow one link per cycle; links stay acyclic under the union rule
            rd_en = 1'b1;
            if (rd_parent == cur_ff) begin
               root_a_in = cur_ff;
               size_a_in = rd_size;
               rd_addr   = elem_b_ff;
               cur_in    = elem_b_ff;
               state_in  = wqu_pkg::SEQ_WALK_B;
            end else begin
               rd_addr = rd_parent;
               cur_in  = rd_parent;
            end
         end
         wqu_pkg::SEQ_WALK_B: begin
            if (rd_parent == cur_ff) begin
               root_b_in = cur_ff;
               size_b_in = rd_size;
               state_in  = wqu_pkg::SEQ_LINK;
            end else begin
               rd_en   = 1'b1;
               rd_addr = rd_parent;
               cur_in  = rd_parent;
            end
         end
         wqu_pkg::SEQ_LINK: begin
            res_root_a_in = wqu_pkg::ElemBits'(root_a_ff);
            res_root_b_in = wqu_pkg::ElemBits'(root_b_ff);
            if (root_a_ff == root_b_ff) begin
               res_joined_in = 1'b0;
               res_size_in   = size_a_ff;
               state_in      = wqu_pkg::SEQ_DONE;
            end else begin
               // Hang the smaller root under the larger one
               res_joined_in = 1'b1;
               res_size_in   = size_a_ff + size_b_ff;
               wr_en         = 1'b1;
               if (size_a_ff < size_b_ff) begin
                  wr_addr = root_a_ff;
                  wr_data = {root_b_ff, size_a_ff};
                  big_in  = root_b_ff;
               end else begin
                  wr_addr = root_b_ff;
                  wr_data = {root_a_ff, size_b_ff};
                  big_in  = root_a_ff;
               end
               state_in = wqu_pkg::SEQ_GROW;
            end
         end
         wqu_pkg::SEQ_GROW: begin
            // Store the combined size at the surviving root
            wr_en    = 1'b1;
            wr_addr  = big_ff;
            wr_data  = {big_ff, res_size_ff};
            state_in = wqu_pkg::SEQ_DONE;
         end
         wqu_pkg::SEQ_DONE: begin
            // Hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_root_a_in = res_root_a_ff;
               rsp_root_b_in = res_root_b_ff;
               rsp_joined_in = res_joined_ff;
               rsp_size_in   = wqu_pkg::SizeBits'(res_size_ff);
               state_in      = wqu_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = wqu_pkg::SEQ_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wqu_pkg::SEQ_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      elem_b_ff     <= elem_b_in;
      root_a_ff     <= root_a_in;
      root_b_ff     <= root_b_in;
      size_a_ff     <= size_a_in;
      size_b_ff     <= size_b_in;
      big_ff        <= big_in;
      res_root_a_ff <= res_root_a_in;
      res_root_b_ff <= res_root_b_in;
      res_joined_ff <= res_joined_in;
      res_size_ff   <= res_size_in;
      rsp_root_a_ff <= rsp_root_a_in;
      rsp_root_b_ff <= rsp_root_b_in;
      rsp_joined_ff <= rsp_joined_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_a      = rsp_root_a_ff;
   assign rsp_root_b      = rsp_root_b_ff;
   assign rsp_joined      = rsp_joined_ff;
   assign rsp_merged_size = rsp_size_ff;

   // A merge always reports two distinct roots
   a_joined_roots_differ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_joined) |-> (rsp_root_a != rsp_root_b))
      else $error("joined response with equal roots");

   // A merged set holds at least two elements
   a_joined_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_joined) |-> (rsp_merged_size >= wqu_pkg::SizeBits'(2)))
      else $error("joined response with size below two");

   // The walk never leaves the table
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wqu_pkg::SEQ_WALK_A || state_ff == wqu_pkg::SEQ_WALK_B)
         |-> (32'(cur_ff) < ELEMENTS))
      else $error("root walk outside the table");

   // A new response is loaded only when the previous one has gone
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_merged_size)
                                    && $stable(rsp_root_a)))
      else $error("stalled response overwritten");

endmodule

@@ design/wqu_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No package dependencies.
module wqu_ram #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 27
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the weighted quick-union engine (weighted_quick_union).
// Holds a disjoint-set predictor, a queue-fed request driver and a response monitor.
// Depends on wqu_pkg and the RTL of weighted_quick_union.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int Elements   = 8192;
   localparam int CycleLimit = 900000;
   localparam int RandomGoal = 1550;
   localparam int DrainTail  = 64;

   typedef logic [wqu_pkg::ElemBits-1:0] elem_type;
   typedef logic [wqu_pkg::SizeBits-1:0] size_type;

   typedef struct packed {
      elem_type elem_a;
      elem_type elem_b;
      logic     wait_empty;   // hold this pair back until every result is in
   } pair_type;

   typedef struct packed {
      elem_type root_a;
      elem_type root_b;
      logic     joined;
      size_type merged_size;
   } union_result_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   elem_type req_element_a = '0;
   elem_type req_element_b = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   elem_type rsp_root_a;
   elem_type rsp_root_b;
   logic     rsp_joined;
   size_type rsp_merged_size;

   // Predictor copy of the forest
   elem_type parent_of [Elements];
   size_type size_of [Elements];

   pair_type         pending_pairs[$];
   union_result_type expected_unions[$];
   int unsigned      sent_count = 0;
   int unsigned      mismatches = 0;
   int unsigned      cycle_count = 0;

   weighted_quick_union u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_element_a   (req_element_a),
      .req_element_b   (req_element_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_root_a      (rsp_root_a),
      .rsp_root_b      (rsp_root_b),
      .rsp_joined      (rsp_joined),
      .rsp_merged_size (rsp_merged_size)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Follow parent links up to the root, bounded by the element count
   function automatic elem_type root_of(input elem_type e);
      elem_type node;
      int       hops;
      node = e;
      for (hops = 0; hops < Elements; hops++) begin
         if (parent_of[node] == node) break;
         node = parent_of[node];
      end
      return node;
   endfunction

   // Apply one union to the predictor forest and return what the block must answer
   function automatic union_result_type join_sets(input elem_type a, input elem_type b);
      union_result_type res;
      elem_type         ra;
      elem_type         rb;
      if (int'(a) >= Elements || int'(b) >= Elements) begin
         res = '{root_a: a, root_b: b, joined: 1'b0, merged_size: '0};
         return res;
      end
      ra = root_of(a);
      rb = root_of(b);
      res.root_a = ra;
      res.root_b = rb;
      res.joined = (ra != rb);
      if (ra == rb) begin
         res.merged_size = size_of[ra];
      end else if (size_of[ra] < size_of[rb]) begin
         parent_of[ra] = rb;
         size_of[rb]   = size_of[rb] + size_of[ra];
         res.merged_size = size_of[rb];
      end else begin
         parent_of[rb] = ra;
         size_of[ra]   = size_of[ra] + size_of[rb];
         res.merged_size = size_of[ra];
      end
      return res;
   endfunction

   function automatic int sender_idle_pct();
      if (sent_count < 520) return 22;
      if (sent_count < 1040) return 52;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (sent_count < 520) return 52;
      if (sent_count < 1040) return 22;
      return 0;
   endfunction

   task automatic queue_pair(input int a, input int b, input bit drain);
      pair_type p;
      p.elem_a = elem_type'(a);
      p.elem_b = elem_type'(b);
      p.wait_empty = drain;
      pending_pairs = {pending_pairs, p};
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Driver: predict on acceptance, then present the next pair or go idle
   always @(posedge clock) begin
      pair_type         nxt;
      union_result_type pred;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pred = join_sets(req_element_a, req_element_b);
            expected_unions = {expected_unions, pred};
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_pairs.size() != 0
                && !(pending_pairs[0].wait_empty && expected_unions.size() != 0)
                && $urandom_range(0, 99) >= sender_idle_pct()) begin
               nxt = pending_pairs.pop_front();
               req_valid     <= 1'b1;
               req_element_a <= nxt.elem_a;
               req_element_b <= nxt.elem_b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Randomly stall the response channel
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
      end
   end

   // Monitor: compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      union_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_unions.size() == 0) begin
            $display("%0t ns: unexpected response: expected none, actual %0d %0d %0d %0d",
                     $time, rsp_root_a, rsp_root_b, rsp_joined, rsp_merged_size);
            mismatches++;
         end else begin
            want = expected_unions.pop_front();
            check_field("root_a", 32'(want.root_a), 32'(rsp_root_a));
            check_field("root_b", 32'(want.root_b), 32'(rsp_root_b));
            check_field("joined", 32'(want.joined), 32'(rsp_joined));
            check_field("merged_size", 32'(want.merged_size), 32'(rsp_merged_size));
         end
      end
   end

   // Bound the run; the clearing pass after reset is well inside this
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      int    added;
      int    kind;
      int    span;
      int    base;
      int    lvl;
      int    stride;
      int    i;
      int    a;
      int    b;
      int    n;
      bit    drain;

      for (i = 0; i < Elements; i++) begin
         parent_of[i] = elem_type'(i);
         size_of[i]   = size_type'(1);
      end

      // Directed: extremes, self-union, same set, both size orders and the tie rule
      queue_pair(0, 0, 1'b0);
      queue_pair(0, 8191, 1'b0);
      queue_pair(8191, 8191, 1'b0);
      queue_pair(8191, 0, 1'b0);
      queue_pair(1, 2, 1'b0);
      queue_pair(2, 1, 1'b0);
      queue_pair(3, 1, 1'b0);
      queue_pair(1, 4, 1'b0);
      queue_pair(8191, 3, 1'b0);
      queue_pair(4095, 4096, 1'b0);
      queue_pair(4096, 4095, 1'b0);
      queue_pair(5461, 2730, 1'b0);
      queue_pair(2730, 8190, 1'b0);
      queue_pair(6, 7, 1'b0);
      queue_pair(8, 9, 1'b0);
      queue_pair(9, 7, 1'b0);
      queue_pair(0, 9, 1'b0);
      queue_pair(4096, 8191, 1'b0);
      queue_pair(7, 4095, 1'b0);
      queue_pair(4095, 7, 1'b0);

      // Random: deep binomial builds, small busy pools, full-range noise
      added = 0;
      drain = 1'b1;
      while (added < RandomGoal) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            // merge equal blocks level by level through random leaves to grow deep trees
            span = 1 << (($urandom_range(0, 9) == 0) ? 8 : $urandom_range(2, 6));
            base = $urandom_range(0, Elements - span);
            for (lvl = 0; (1 << lvl) < span; lvl++) begin
               stride = 1 << lvl;
               for (i = 0; i < span; i += 2 * stride) begin
                  a = base + i + $urandom_range(0, stride - 1);
                  b = base + i + stride + $urandom_range(0, stride - 1);
                  if ($urandom_range(0, 1)) queue_pair(b, a, drain);
                  else queue_pair(a, b, drain);
                  drain = 1'b0;
                  added++;
               end
            end
         end else if (kind <= 7) begin
            // hammer a small window so same-set pairs and uneven sizes show up
            span = $urandom_range(8, 64);
            base = $urandom_range(0, Elements - span);
            for (n = 0; n < 24; n++) begin
               queue_pair(base + $urandom_range(0, span - 1),
                          base + $urandom_range(0, span - 1), drain);
               drain = 1'b0;
               added++;
            end
         end else begin
            for (n = 0; n < 10; n++) begin
               queue_pair($urandom_range(0, Elements - 1), $urandom_range(0, Elements - 1),
                          drain);
               drain = 1'b0;
               added++;
            end
         end
         if ($urandom_range(0, 7) == 0) drain = 1'b1;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for every pair to go out and every response to come back
      do @(posedge clock);
      while (pending_pairs.size() != 0 || req_valid || expected_unions.size() != 0);
      repeat (DrainTail) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/wqu_pkg.sv
design/wqu_ram.sv
design/weighted_quick_union.sv
tb/tb.sv
